[rtl/i2cms_pkg.sv]
// Package for the I2C master bit sequencer: phase encoding, command codes
// and segment hold counts. No dependencies.
`default_nettype none

package i2cms_pkg;

	// segment lengths in ticks
	localparam int unsigned SETUP_TICKS    = 4;
	localparam int unsigned HALF_BIT_TICKS = 2;

	localparam logic [2:0] HOLD_S = (SETUP_TICKS > 0) ? 3'(SETUP_TICKS - 1) : 3'd0;
	localparam logic [2:0] HOLD_H = (HALF_BIT_TICKS > 0) ? 3'(HALF_BIT_TICKS - 1) : 3'd0;

	localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

	// command codes on the mode field
	localparam logic [2:0] MODE_START = 3'd0;
	localparam logic [2:0] MODE_STOP  = 3'd1;
	localparam logic [2:0] MODE_WRITE = 3'd2;
	localparam logic [2:0] MODE_WAIT  = 3'd3;
	localparam logic [2:0] MODE_READ  = 3'd4;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_ST_A,
		PH_ST_B,
		PH_SP_A,
		PH_SP_B,
		PH_WR_D,
		PH_WR_H,
		PH_WR_L,
		PH_WA_A,
		PH_WA_B,
		PH_WA_POLL,
		PH_RD_L,
		PH_RD_H,
		PH_AK_L,
		PH_AK_H
	} phase_t;

endpackage

`default_nettype wire

[rtl/i2c_master_bit_sequencer.sv]
// I2C master bit sequencer, top level: tick handshake, phase sequencer,
// pin and data registers, result register. Depends on i2cms_pkg.
//
// Usage: every input item is one time tick. It carries an optional command
// (cmd_valid, mode, tx_byte, send_ack) and the sampled SDA level sda_in.
// For each accepted item exactly one result item comes back with the pin
// levels (scl_out, sda_out, sda_enable), busy_res, a one-tick done_res,
// the last read byte rx_byte and the ack_error flag, all as they stand
// after that tick.
// The tick's result is in the result register on the cycle after
// acceptance. Throughput is one tick per cycle unless the receiver stalls;
// the phase sequencer and its counters advance once per accepted tick.
// in_ready is high while the result register is empty or is being taken
// in the same cycle, so a receiver that stalls holds the result and, one
// item later, stalls the input side; no tick is dropped.
// Commands arriving while a sequence runs are ignored, as are unknown
// mode codes. The ack_timeout register is written through the cfg
// channel, which is always ready; write it only while the block is idle.
// Reset (arst_n low) returns to idle with SCL high, SDA released, an empty
// result register and ack_timeout at 250.
`default_nettype none

module i2c_master_bit_sequencer (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// configuration
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [7:0] cfg_data,
	// tick input
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       cmd_valid,
	input  wire logic [2:0] mode,
	input  wire logic [7:0] tx_byte,
	input  wire logic       send_ack,
	input  wire logic       sda_in,
	// result output
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            scl_out,
	output logic            sda_out,
	output logic            sda_enable,
	output logic            busy_res,
	output logic            done_res,
	output logic [7:0]      rx_byte,
	output logic            ack_error
);

	i2cms_pkg::phase_t phase_q, phase_d;
	logic [2:0] delay_q, delay_d;
	logic [3:0] bit_q, bit_d;
	logic [7:0] shift_q, shift_d;
	logic [7:0] wait_q, wait_d;
	logic [7:0] timeout_q;
	logic       ack_choice_q, ack_choice_d;
	logic       scl_q, scl_d;
	logic       sda_q, sda_d;
	logic       drive_q, drive_d;
	logic       err_q, err_d;
	logic [7:0] rx_q, rx_d;
	logic       done;

	logic       out_valid_q;
	logic       scl_out_q, sda_out_q, sda_enable_q, busy_q, done_out_q, err_out_q;
	logic [7:0] rx_out_q;

	logic       accept;
	logic       is_idle;
	logic       hold_run;
	logic       timeout_hit;
	logic [3:0] bit_inc;
	logic       bit_last;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;

	assign is_idle     = (phase_q == i2cms_pkg::PH_IDLE) || (phase_q > i2cms_pkg::PH_AK_H);
	assign hold_run    = !is_idle && (delay_q != 3'd0) && (phase_q != i2cms_pkg::PH_WA_POLL);
	assign timeout_hit = wait_q >= timeout_q;
	assign bit_inc     = bit_q + 4'd1;
	assign bit_last    = bit_inc[3];

	// next phase, hold counter and done
	always_comb begin
		phase_d = phase_q;
		delay_d = delay_q;
		done    = 1'b0;
		if (is_idle) begin
			phase_d = i2cms_pkg::PH_IDLE;
			if (cmd_valid) begin
				unique case (mode)
					i2cms_pkg::MODE_START: begin
						phase_d = i2cms_pkg::PH_ST_A;
						delay_d = i2cms_pkg::HOLD_S;
					end
					i2cms_pkg::MODE_STOP: begin
						phase_d = i2cms_pkg::PH_SP_A;
						delay_d = i2cms_pkg::HOLD_S;
					end
					i2cms_pkg::MODE_WRITE: begin
						phase_d = i2cms_pkg::PH_WR_D;
						delay_d = i2cms_pkg::HOLD_H;
					end
					i2cms_pkg::MODE_WAIT: begin
						phase_d = i2cms_pkg::PH_WA_A;
						delay_d = 3'd0;
					end
					i2cms_pkg::MODE_READ: begin
						phase_d = i2cms_pkg::PH_RD_L;
						delay_d = i2cms_pkg::HOLD_H;
					end
					default: ;
				endcase
			end
		end else if (hold_run) begin
			delay_d = delay_q - 3'd1;
		end else begin
			unique case (phase_q)
				i2cms_pkg::PH_ST_A: begin
					phase_d = i2cms_pkg::PH_ST_B;
					delay_d = i2cms_pkg::HOLD_S;
				end
				i2cms_pkg::PH_ST_B: done = 1'b1;
				i2cms_pkg::PH_SP_A: begin
					phase_d = i2cms_pkg::PH_SP_B;
					delay_d = i2cms_pkg::HOLD_S;
				end
				i2cms_pkg::PH_SP_B: done = 1'b1;
				i2cms_pkg::PH_WR_D: begin
					phase_d = i2cms_pkg::PH_WR_H;
					delay_d = i2cms_pkg::HOLD_H;
				end
				i2cms_pkg::PH_WR_H: begin
					phase_d = i2cms_pkg::PH_WR_L;
					delay_d = i2cms_pkg::HOLD_H;
				end
				i2cms_pkg::PH_WR_L: begin
					if (bit_last) begin
						done = 1'b1;
					end else begin
						phase_d = i2cms_pkg::PH_WR_D;
						delay_d = i2cms_pkg::HOLD_H;
					end
				end
				i2cms_pkg::PH_WA_A: begin
					phase_d = i2cms_pkg::PH_WA_B;
					delay_d = 3'd0;
				end
				i2cms_pkg::PH_WA_B, i2cms_pkg::PH_WA_POLL: begin
					phase_d = i2cms_pkg::PH_WA_POLL;
					if (!sda_in) begin
						done = 1'b1;
					end else if (timeout_hit) begin
						phase_d = i2cms_pkg::PH_SP_A;
						delay_d = i2cms_pkg::HOLD_S;
					end
				end
				i2cms_pkg::PH_RD_L: begin
					phase_d = i2cms_pkg::PH_RD_H;
					delay_d = 3'd0;
				end
				i2cms_pkg::PH_RD_H: begin
					phase_d = bit_last ? i2cms_pkg::PH_AK_L : i2cms_pkg::PH_RD_L;
					delay_d = i2cms_pkg::HOLD_H;
				end
				i2cms_pkg::PH_AK_L: begin
					phase_d = i2cms_pkg::PH_AK_H;
					delay_d = i2cms_pkg::HOLD_H;
				end
				i2cms_pkg::PH_AK_H: done = 1'b1;
				default: phase_d = i2cms_pkg::PH_IDLE;
			endcase
			if (done) begin
				phase_d = i2cms_pkg::PH_IDLE;
				delay_d = 3'd0;
			end
		end
	end

	// pins, shifter, counters and flags
	always_comb begin
		bit_d        = bit_q;
		shift_d      = shift_q;
		wait_d       = wait_q;
		ack_choice_d = ack_choice_q;
		scl_d        = scl_q;
		sda_d        = sda_q;
		drive_d      = drive_q;
		err_d        = err_q;
		rx_d         = rx_q;
		if (is_idle) begin
			if (cmd_valid) begin
				unique case (mode)
					i2cms_pkg::MODE_START: begin
						drive_d = 1'b1;
						sda_d   = 1'b1;
						scl_d   = 1'b1;
					end
					i2cms_pkg::MODE_STOP: begin
						drive_d = 1'b1;
						scl_d   = 1'b0;
						sda_d   = 1'b0;
					end
					i2cms_pkg::MODE_WRITE: begin
						drive_d = 1'b1;
						bit_d   = 4'd0;
						scl_d   = 1'b0;
						sda_d   = tx_byte[7];
						shift_d = {tx_byte[6:0], 1'b0};
					end
					i2cms_pkg::MODE_WAIT: begin
						err_d   = 1'b0;
						wait_d  = 8'd0;
						drive_d = 1'b0;
						sda_d   = 1'b1;
					end
					i2cms_pkg::MODE_READ: begin
						ack_choice_d = send_ack;
						shift_d      = 8'd0;
						bit_d        = 4'd0;
						drive_d      = 1'b0;
						sda_d        = 1'b1;
						scl_d        = 1'b0;
					end
					default: ;
				endcase
			end
		end else if (!hold_run) begin
			unique case (phase_q)
				i2cms_pkg::PH_ST_A: sda_d = 1'b0;
				i2cms_pkg::PH_ST_B: scl_d = 1'b0;
				i2cms_pkg::PH_SP_A: begin
					scl_d = 1'b1;
					sda_d = 1'b1;
				end
				i2cms_pkg::PH_WR_D: scl_d = 1'b1;
				i2cms_pkg::PH_WR_H: scl_d = 1'b0;
				i2cms_pkg::PH_WR_L: begin
					if (bit_last) begin
						bit_d = 4'd0;
					end else begin
						bit_d   = bit_inc;
						scl_d   = 1'b0;
						sda_d   = shift_q[7];
						shift_d = {shift_q[6:0], 1'b0};
					end
				end
				i2cms_pkg::PH_WA_A: scl_d = 1'b1;
				i2cms_pkg::PH_WA_B, i2cms_pkg::PH_WA_POLL: begin
					if (!sda_in) begin
						scl_d = 1'b0;
					end else if (timeout_hit) begin
						// give up: flag and run a stop
						err_d   = 1'b1;
						drive_d = 1'b1;
						scl_d   = 1'b0;
						sda_d   = 1'b0;
					end else begin
						wait_d = wait_q + 8'd1;
					end
				end
				i2cms_pkg::PH_RD_L: begin
					scl_d   = 1'b1;
					shift_d = {shift_q[6:0], sda_in};
				end
				i2cms_pkg::PH_RD_H: begin
					scl_d = 1'b0;
					if (bit_last) begin
						bit_d   = 4'd0;
						rx_d    = shift_q;
						drive_d = 1'b1;
						sda_d   = !ack_choice_q;
					end else begin
						bit_d = bit_inc;
					end
				end
				i2cms_pkg::PH_AK_L: scl_d = 1'b1;
				i2cms_pkg::PH_AK_H: scl_d = 1'b0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= i2cms_pkg::ACK_TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			timeout_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= i2cms_pkg::PH_IDLE;
			delay_q      <= 3'd0;
			bit_q        <= 4'd0;
			shift_q      <= 8'd0;
			wait_q       <= 8'd0;
			ack_choice_q <= 1'b0;
			scl_q        <= 1'b1;
			sda_q        <= 1'b1;
			drive_q      <= 1'b0;
			err_q        <= 1'b0;
			rx_q         <= 8'd0;
		end else if (accept) begin
			phase_q      <= phase_d;
			delay_q      <= delay_d;
			bit_q        <= bit_d;
			shift_q      <= shift_d;
			wait_q       <= wait_d;
			ack_choice_q <= ack_choice_d;
			scl_q        <= scl_d;
			sda_q        <= sda_d;
			drive_q      <= drive_d;
			err_q        <= err_d;
			rx_q         <= rx_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			scl_out_q    <= scl_d;
			sda_out_q    <= sda_d;
			sda_enable_q <= drive_d;
			busy_q       <= (phase_d != i2cms_pkg::PH_IDLE);
			done_out_q   <= done;
			rx_out_q     <= rx_d;
			err_out_q    <= err_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign scl_out    = scl_out_q;
	assign sda_out    = sda_out_q;
	assign sda_enable = sda_enable_q;
	assign busy_res   = busy_q;
	assign done_res   = done_out_q;
	assign rx_byte    = rx_out_q;
	assign ack_error  = err_out_q;

	// a finished command is never reported as still running
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && done_out_q |-> !busy_q)
		else $error("done pulse together with busy");

	// a released SDA reads back as a high level
	a_release_high: assert property (@(posedge clk) disable iff (!arst_n)
		!drive_q |-> sda_q)
		else $error("SDA released with low level");

	// polling never carries a pending hold
	a_poll_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == i2cms_pkg::PH_WA_POLL |-> delay_q == 3'd0)
		else $error("hold count left in ack poll");

	// an item is taken only when the result register has room
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (!out_valid_q || out_ready))
		else $error("result overwritten while stalled");

endmodule

`default_nettype wire

[dv/i2c_master_bit_sequencer_tb.sv]
// Testbench for i2c_master_bit_sequencer: drives ticks through the input handshake, predicts the
// pin and status result of every tick and checks each one as it leaves the block.
// Depends on i2cms_pkg and the block itself.

module i2c_master_bit_sequencer_tb;
	import i2cms_pkg::*;

	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       sda_en;
		logic       busy;
		logic       done;
		logic [7:0] rx;
		logic       err;
	} pin_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_data = 8'd0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       cmd_valid = 1'b0;
	logic [2:0] mode = 3'd0;
	logic [7:0] tx_byte = 8'd0;
	logic       send_ack = 1'b0;
	logic       sda_in = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       scl_out;
	logic       sda_out;
	logic       sda_enable;
	logic       busy_res;
	logic       done_res;
	logic [7:0] rx_byte;
	logic       ack_error;

	i2c_master_bit_sequencer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd_valid  (cmd_valid),
		.mode       (mode),
		.tx_byte    (tx_byte),
		.send_ack   (send_ack),
		.sda_in     (sda_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.scl_out    (scl_out),
		.sda_out    (sda_out),
		.sda_enable (sda_enable),
		.busy_res   (busy_res),
		.done_res   (done_res),
		.rx_byte    (rx_byte),
		.ack_error  (ack_error)
	);

	// predicted sequencer state
	phase_t     seq_phase = PH_IDLE;
	logic [3:0] seq_bit = 4'd0;
	logic [7:0] seq_shift = 8'd0;
	logic [2:0] seq_delay = 3'd0;
	logic [7:0] seq_wait = 8'd0;
	logic       seq_ack_choice = 1'b0;
	logic       seq_scl = 1'b1;
	logic       seq_sda = 1'b1;
	logic       seq_drive = 1'b0;
	logic       seq_err = 1'b0;
	logic [7:0] seq_rx = 8'd0;
	logic [7:0] seq_timeout = ACK_TIMEOUT_RESET;

	pin_result_t expected_pins[$];
	pin_result_t want_pins;

	int  ticks_sent = 0;
	int  results_checked = 0;
	int  mismatches = 0;
	int  commands_started = 0;
	int  timeouts_seen = 0;
	int  bytes_read = 0;
	int  stall_left = 0;
	bit  steady = 1'b0;

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("FAILURE");
		$finish;
	end

	function automatic int pause_len();
		return steady ? 0 : $urandom_range(0, 4);
	endfunction

	// number of high polls before the slave pulls SDA low
	function automatic int pick_highs(input int t);
		if (t > 16 && $urandom_range(0, 3) != 0)
			return $urandom_range(0, 3);
		case ($urandom_range(0, 7))
		0: return 0;
		1: return t;
		2: return t + 1;
		3: return (t > 0) ? t - 1 : 0;
		default: return $urandom_range(0, 3);
		endcase
	endfunction

	task automatic enter_phase(input phase_t p, input logic [2:0] hold);
		seq_phase = p;
		seq_delay = hold;
	endtask

	task automatic begin_stop();
		seq_drive = 1'b1;
		seq_scl = 1'b0;
		seq_sda = 1'b0;
		enter_phase(PH_SP_A, HOLD_S);
	endtask

	task automatic load_write_bit();
		seq_scl = 1'b0;
		seq_sda = seq_shift[7];
		seq_shift = {seq_shift[6:0], 1'b0};
		enter_phase(PH_WR_D, HOLD_H);
	endtask

	// advance the predicted sequencer by one tick and queue its result
	task automatic step_sequencer(input logic cv, input logic [2:0] md, input logic [7:0] tx,
			input logic sa, input logic si);
		logic        fin;
		pin_result_t r;
		fin = 1'b0;
		if (seq_phase == PH_IDLE) begin
			if (cv) begin
				case (md)
				MODE_START: begin
					seq_drive = 1'b1;
					seq_sda = 1'b1;
					seq_scl = 1'b1;
					enter_phase(PH_ST_A, HOLD_S);
				end
				MODE_STOP: begin_stop();
				MODE_WRITE: begin
					seq_drive = 1'b1;
					seq_shift = tx;
					seq_bit = 4'd0;
					load_write_bit();
				end
				MODE_WAIT: begin
					seq_err = 1'b0;
					seq_wait = 8'd0;
					seq_drive = 1'b0;
					seq_sda = 1'b1;
					enter_phase(PH_WA_A, 3'd0);
				end
				MODE_READ: begin
					seq_ack_choice = sa;
					seq_shift = 8'd0;
					seq_bit = 4'd0;
					seq_drive = 1'b0;
					seq_sda = 1'b1;
					seq_scl = 1'b0;
					enter_phase(PH_RD_L, HOLD_H);
				end
				default: ;
				endcase
				if (md <= MODE_READ)
					commands_started++;
			end
		end else if (seq_delay != 3'd0 && seq_phase != PH_WA_POLL) begin
			seq_delay = seq_delay - 3'd1;
		end else begin
			case (seq_phase)
			PH_ST_A: begin
				seq_sda = 1'b0;
				enter_phase(PH_ST_B, HOLD_S);
			end
			PH_ST_B: begin
				seq_scl = 1'b0;
				fin = 1'b1;
			end
			PH_SP_A: begin
				seq_scl = 1'b1;
				seq_sda = 1'b1;
				enter_phase(PH_SP_B, HOLD_S);
			end
			PH_SP_B: fin = 1'b1;
			PH_WR_D: begin
				seq_scl = 1'b1;
				enter_phase(PH_WR_H, HOLD_H);
			end
			PH_WR_H: begin
				seq_scl = 1'b0;
				enter_phase(PH_WR_L, HOLD_H);
			end
			PH_WR_L: begin
				seq_bit = seq_bit + 4'd1;
				if (seq_bit >= 4'd8) begin
					seq_bit = 4'd0;
					fin = 1'b1;
				end else begin
					load_write_bit();
				end
			end
			PH_WA_A: begin
				seq_scl = 1'b1;
				enter_phase(PH_WA_B, 3'd0);
			end
			PH_WA_B, PH_WA_POLL: begin
				seq_phase = PH_WA_POLL;
				if (!si) begin
					seq_scl = 1'b0;
					fin = 1'b1;
				end else if (seq_wait >= seq_timeout) begin
					// give up: flag the error and release the bus with a stop
					seq_err = 1'b1;
					timeouts_seen++;
					begin_stop();
				end else begin
					seq_wait = seq_wait + 8'd1;
				end
			end
			PH_RD_L: begin
				seq_scl = 1'b1;
				seq_shift = {seq_shift[6:0], si};
				enter_phase(PH_RD_H, 3'd0);
			end
			PH_RD_H: begin
				seq_bit = seq_bit + 4'd1;
				seq_scl = 1'b0;
				if (seq_bit >= 4'd8) begin
					seq_bit = 4'd0;
					seq_rx = seq_shift;
					seq_drive = 1'b1;
					seq_sda = !seq_ack_choice;
					bytes_read++;
					enter_phase(PH_AK_L, HOLD_H);
				end else begin
					enter_phase(PH_RD_L, HOLD_H);
				end
			end
			PH_AK_L: begin
				seq_scl = 1'b1;
				enter_phase(PH_AK_H, HOLD_H);
			end
			PH_AK_H: begin
				seq_scl = 1'b0;
				fin = 1'b1;
			end
			default: seq_phase = PH_IDLE;
			endcase
			if (fin) begin
				seq_phase = PH_IDLE;
				seq_delay = 3'd0;
			end
		end
		r.scl = seq_scl;
		r.sda = seq_sda;
		r.sda_en = seq_drive;
		r.busy = (seq_phase != PH_IDLE);
		r.done = fin;
		r.rx = seq_rx;
		r.err = seq_err;
		expected_pins.push_back(r);
	endtask

	// offer one tick; leaves in_valid high so the next tick can follow back to back
	task automatic send_tick(input logic cv, input logic [2:0] md, input logic [7:0] tx,
			input logic sa, input logic si);
		int gap;
		gap = pause_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd_valid <= cv;
		mode <= md;
		tx_byte <= tx;
		send_ack <= sa;
		sda_in <= si;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		step_sequencer(cv, md, tx, sa, si);
		ticks_sent++;
	endtask

	task automatic send_idle(input int n);
		repeat (n) send_tick(1'b0, 3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
			1'($urandom));
	endtask

	// issue a command and keep ticking until the sequencer is idle again;
	// line < 0 gives random SDA, odds > 0 throws in commands while busy
	task automatic run_command(input logic [2:0] md, input logic [7:0] tx, input logic sa,
			input int highs, input int line, input int odds);
		int   left;
		logic poll;
		logic si;
		left = highs;
		send_tick(1'b1, md, tx, sa, 1'($urandom));
		while (seq_phase != PH_IDLE) begin
			poll = (seq_phase == PH_WA_B) || (seq_phase == PH_WA_POLL);
			if (poll) begin
				si = (left > 0);
				if (left > 0)
					left--;
			end else if (line < 0) begin
				si = 1'($urandom);
			end else begin
				si = line[0];
			end
			send_tick((odds > 0) && ($urandom_range(1, odds) == 1),
				3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom), si);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_pins.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic set_timeout(input logic [7:0] value);
		wait_drained();
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		seq_timeout = value;
	endtask

	task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	task automatic test_start_stop();
		run_command(MODE_START, 8'h00, 1'b0, 0, -1, 0);
		run_command(MODE_STOP, 8'hFF, 1'b1, 0, -1, 0);
	endtask

	task automatic test_write_extremes();
		run_command(MODE_WRITE, 8'h00, 1'b0, 0, 0, 0);
		run_command(MODE_WRITE, 8'hFF, 1'b1, 0, 1, 0);
		run_command(MODE_WRITE, 8'hA5, 1'b0, 0, -1, 0);
	endtask

	// runs at the reset value of ack_timeout
	task automatic test_wait_ack();
		run_command(MODE_WAIT, 8'h00, 1'b0, 0, -1, 0);
		run_command(MODE_WAIT, 8'h00, 1'b0, 250, -1, 0);
		run_command(MODE_WAIT, 8'h00, 1'b0, 251, -1, 0);
	endtask

	task automatic test_read_byte();
		run_command(MODE_READ, 8'h00, 1'b1, 0, 1, 0);
		run_command(MODE_READ, 8'hFF, 1'b0, 0, 0, 0);
		run_command(MODE_READ, 8'h5A, 1'b1, 0, -1, 0);
	endtask

	task automatic test_ignored_commands();
		run_command(3'd5, 8'hFF, 1'b1, 0, -1, 0);
		run_command(3'd6, 8'h00, 1'b0, 0, -1, 0);
		run_command(3'd7, 8'hFF, 1'b1, 0, -1, 0);
		// hammer commands on every busy tick, including the one that ends the sequence
		run_command(MODE_START, 8'h3C, 1'b0, 0, -1, 1);
		run_command(MODE_READ, 8'hC3, 1'b1, 0, -1, 1);
	endtask

	task automatic test_timeout_settings();
		set_timeout(8'd0);
		run_command(MODE_WAIT, 8'h00, 1'b0, 0, -1, 0);
		run_command(MODE_WAIT, 8'h00, 1'b0, 1, -1, 0);
		set_timeout(8'd255);
		run_command(MODE_WAIT, 8'h00, 1'b0, 256, -1, 0);
		set_timeout(8'd1);
		run_command(MODE_WAIT, 8'h00, 1'b0, 1, -1, 0);
		run_command(MODE_WAIT, 8'h00, 1'b0, 2, -1, 0);
	endtask

	task automatic run_transfer();
		int n;
		run_command(MODE_START, 8'($urandom), 1'($urandom), 0, -1, 16);
		run_command(MODE_WRITE, 8'($urandom), 1'($urandom), 0, -1, 16);
		run_command(MODE_WAIT, 8'($urandom), 1'($urandom), pick_highs(seq_timeout), -1, 16);
		n = $urandom_range(1, 3);
		repeat (n) begin
			if ($urandom_range(0, 1) == 1) begin
				run_command(MODE_WRITE, 8'($urandom), 1'($urandom), 0, -1, 16);
				run_command(MODE_WAIT, 8'($urandom), 1'($urandom), pick_highs(seq_timeout), -1,
					16);
			end else begin
				run_command(MODE_READ, 8'($urandom), 1'($urandom), 0, -1, 16);
			end
		end
		if ($urandom_range(0, 2) == 0)
			send_idle($urandom_range(1, 3));
		run_command(MODE_STOP, 8'($urandom), 1'($urandom), 0, -1, 16);
	endtask

	task automatic test_random_traffic();
		logic [7:0] limits [5];
		int         first;
		limits = '{8'd1, 8'd0, 8'd255, 8'd7, 8'd0};
		limits[4] = 8'($urandom_range(2, 254));
		foreach (limits[i]) begin
			set_timeout(limits[i]);
			first = ticks_sent;
			while (ticks_sent - first < 40) begin
				steady = ($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 9) < 7) begin
					run_transfer();
				end else begin
					run_command(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
						pick_highs(seq_timeout), -1, 4);
					send_idle($urandom_range(0, 2));
				end
				// hold off until the block has returned everything
				if ($urandom_range(0, 15) == 0)
					wait_drained();
			end
		end
		steady = 1'b0;
	endtask

	// result side: check each result, then draw the next stall
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_checked++;
			if (expected_pins.size() == 0) begin
				$error("result item with nothing expected");
				mismatches++;
			end else begin
				want_pins = expected_pins.pop_front();
				compare_field("scl_out", 8'(want_pins.scl), 8'(scl_out));
				compare_field("sda_out", 8'(want_pins.sda), 8'(sda_out));
				compare_field("sda_enable", 8'(want_pins.sda_en), 8'(sda_enable));
				compare_field("busy_res", 8'(want_pins.busy), 8'(busy_res));
				compare_field("done_res", 8'(want_pins.done), 8'(done_res));
				compare_field("rx_byte", want_pins.rx, rx_byte);
				compare_field("ack_error", 8'(want_pins.err), 8'(ack_error));
			end
			stall_left = pause_len();
		end
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else begin
			out_ready <= 1'b1;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_start_stop();
		test_write_extremes();
		test_wait_ack();
		test_read_byte();
		test_ignored_commands();
		test_timeout_settings();
		test_random_traffic();
		wait_drained();
		repeat (4) @(posedge clk);
		$display("Ran %0d ticks, checked %0d results: %0d commands started, %0d bytes read,",
			ticks_sent, results_checked, commands_started, bytes_read);
		$display("%0d acknowledge timeouts, ack_timeout swept from 0 to 255.", timeouts_seen);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
